/* design/avbd_pkg.sv */
package avbd_pkg;

  // Depths of the sample delay line and the two vote windows
  localparam int DELAY_DEPTH = 20;
  localparam int V_WINDOW    = 11;
  localparam int A_WINDOW    = 30;

  // The line keeps one tap fewer than its depth: the current sample is not stored
  localparam int LINE_TAPS   = DELAY_DEPTH - 1;
  localparam int LINE_FILL_W = $clog2(DELAY_DEPTH);

  localparam int V_FILL_W = $clog2(V_WINDOW + 1);
  localparam int V_SUM_W  = $clog2(V_WINDOW + 2);
  localparam int V_HALF   = V_WINDOW / 2;
  localparam int A_FILL_W = $clog2(A_WINDOW + 1);
  localparam int A_SUM_W  = $clog2(A_WINDOW + 2);
  localparam int A_HALF   = A_WINDOW / 2;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 17;
  localparam int POL_W    = 2;
  localparam int LIM_W    = 16;
  localparam int AGE_W    = 32;
  localparam int PROD_W   = SAMPLE_W + POL_W;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Bus widths
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int OBUF_DEPTH  = 2;

  // Register reset values
  localparam logic signed [THR_W-1:0] V_THR_RST   = 17'sd161;
  localparam logic signed [THR_W-1:0] A_THR_RST   = 17'sd72;
  localparam logic signed [POL_W-1:0] V_POL_RST   = -2'sd1;
  localparam logic signed [POL_W-1:0] A_POL_RST   = 2'sd1;
  localparam logic [LIM_W-1:0]        A_ESC_RST   = 16'd1000;
  localparam logic [LIM_W-1:0]        V_ESC_RST   = 16'd900;
  localparam logic [LIM_W-1:0]        A_BLANK_RST = 16'd30;
  localparam logic [LIM_W-1:0]        V_BLANK_RST = 16'd11;

  typedef enum logic [2:0] {
    REG_V_THR,
    REG_A_THR,
    REG_V_POL,
    REG_A_POL,
    REG_A_ESC,
    REG_V_ESC,
    REG_A_BLANK,
    REG_V_BLANK
  } reg_idx_e;

  typedef enum logic [1:0] {
    BEAT_NONE   = 2'd0,
    BEAT_ATRIAL = 2'd1,
    BEAT_VENT   = 2'd2
  } beat_e;

  typedef enum logic [1:0] {
    STIM_NONE   = 2'd0,
    STIM_ATRIAL = 2'd1,
    STIM_VENT   = 2'd2
  } stim_e;

  typedef struct packed {
    logic signed [THR_W-1:0] v_threshold;
    logic signed [THR_W-1:0] a_threshold;
    logic signed [POL_W-1:0] v_polarity;
    logic signed [POL_W-1:0] a_polarity;
    logic [LIM_W-1:0]        a_escape_limit;
    logic [LIM_W-1:0]        v_escape_limit;
    logic [LIM_W-1:0]        a_capture_blank;
    logic [LIM_W-1:0]        v_capture_blank;
  } cfg_t;

  // Input item, sample in the lowest bits
  typedef struct packed {
    logic                       v_pace_clr;
    logic                       a_pace_clr;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  // Result item, beat in the lowest bits
  typedef struct packed {
    stim_e stim;
    beat_e beat;
  } res_item_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int RES_ITEM_W = $bits(res_item_t);

  // Saturating age increment
  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] age);
    return (age == AGE_MAX) ? age : age + 1'b1;
  endfunction

endpackage

/* design/avbd_regs.sv */
module avbd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [avbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [avbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [avbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output avbd_pkg::cfg_t                cfg_o
);

  avbd_pkg::cfg_t   cfg_q;
  avbd_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = avbd_pkg::reg_idx_e'(paddr[avbd_pkg::PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.v_threshold     <= avbd_pkg::V_THR_RST;
      cfg_q.a_threshold     <= avbd_pkg::A_THR_RST;
      cfg_q.v_polarity      <= avbd_pkg::V_POL_RST;
      cfg_q.a_polarity      <= avbd_pkg::A_POL_RST;
      cfg_q.a_escape_limit  <= avbd_pkg::A_ESC_RST;
      cfg_q.v_escape_limit  <= avbd_pkg::V_ESC_RST;
      cfg_q.a_capture_blank <= avbd_pkg::A_BLANK_RST;
      cfg_q.v_capture_blank <= avbd_pkg::V_BLANK_RST;
    end else if (wr_en) begin
      unique case (idx)
        avbd_pkg::REG_V_THR:   cfg_q.v_threshold     <= pwdata[avbd_pkg::THR_W-1:0];
        avbd_pkg::REG_A_THR:   cfg_q.a_threshold     <= pwdata[avbd_pkg::THR_W-1:0];
        avbd_pkg::REG_V_POL:   cfg_q.v_polarity      <= pwdata[avbd_pkg::POL_W-1:0];
        avbd_pkg::REG_A_POL:   cfg_q.a_polarity      <= pwdata[avbd_pkg::POL_W-1:0];
        avbd_pkg::REG_A_ESC:   cfg_q.a_escape_limit  <= pwdata[avbd_pkg::LIM_W-1:0];
        avbd_pkg::REG_V_ESC:   cfg_q.v_escape_limit  <= pwdata[avbd_pkg::LIM_W-1:0];
        avbd_pkg::REG_A_BLANK: cfg_q.a_capture_blank <= pwdata[avbd_pkg::LIM_W-1:0];
        avbd_pkg::REG_V_BLANK: cfg_q.v_capture_blank <= pwdata[avbd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, signed registers sign-extended
  always_comb begin
    unique case (idx)
      avbd_pkg::REG_V_THR: prdata = {{(avbd_pkg::PDATA_W - avbd_pkg::THR_W)
                                      {cfg_q.v_threshold[avbd_pkg::THR_W-1]}},
                                     cfg_q.v_threshold};
      avbd_pkg::REG_A_THR: prdata = {{(avbd_pkg::PDATA_W - avbd_pkg::THR_W)
                                      {cfg_q.a_threshold[avbd_pkg::THR_W-1]}},
                                     cfg_q.a_threshold};
      avbd_pkg::REG_V_POL: prdata = {{(avbd_pkg::PDATA_W - avbd_pkg::POL_W)
                                      {cfg_q.v_polarity[avbd_pkg::POL_W-1]}},
                                     cfg_q.v_polarity};
      avbd_pkg::REG_A_POL: prdata = {{(avbd_pkg::PDATA_W - avbd_pkg::POL_W)
                                      {cfg_q.a_polarity[avbd_pkg::POL_W-1]}},
                                     cfg_q.a_polarity};
      avbd_pkg::REG_A_ESC:   prdata = avbd_pkg::PDATA_W'(cfg_q.a_escape_limit);
      avbd_pkg::REG_V_ESC:   prdata = avbd_pkg::PDATA_W'(cfg_q.v_escape_limit);
      avbd_pkg::REG_A_BLANK: prdata = avbd_pkg::PDATA_W'(cfg_q.a_capture_blank);
      avbd_pkg::REG_V_BLANK: prdata = avbd_pkg::PDATA_W'(cfg_q.v_capture_blank);
      default:               prdata = '0;
    endcase
  end

endmodule

/* design/avbd_in_reg.sv */
module avbd_in_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: sample[15:0], a_pace_clr[16], v_pace_clr[17], zero pad
  input  logic [avbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              take_i,
  output logic                              valid_o,
  output avbd_pkg::in_item_t                item_o
);

  logic               valid_q;
  avbd_pkg::in_item_t item_q;
  logic               accept;

  // Refill whenever the held item leaves this cycle or the stage is empty
  assign s_axis_tready = !valid_q || take_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign valid_o       = valid_q;
  assign item_o        = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= avbd_pkg::in_item_t'(s_axis_tdata[avbd_pkg::IN_ITEM_W-1:0]);
    end
  end

endmodule

/* design/avbd_detect.sv */
module avbd_detect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avbd_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  avbd_pkg::in_item_t  item_i,
  output avbd_pkg::res_item_t res_o
);

  // Delay line taps: tap k holds the sample from k+1 items back
  logic signed [avbd_pkg::SAMPLE_W-1:0] line_q [avbd_pkg::LINE_TAPS];
  logic [avbd_pkg::LINE_FILL_W-1:0]     line_fill_q, line_fill_d;

  logic [avbd_pkg::V_WINDOW-1:0] v_bits_q, v_bits_d;
  logic [avbd_pkg::V_FILL_W-1:0] v_fill_q, v_fill_d;
  logic [avbd_pkg::V_SUM_W-1:0]  v_sum_q, v_sum_d;
  logic [avbd_pkg::A_WINDOW-1:0] a_bits_q, a_bits_d;
  logic [avbd_pkg::A_FILL_W-1:0] a_fill_q, a_fill_d;
  logic [avbd_pkg::A_SUM_W-1:0]  a_sum_q, a_sum_d;

  logic [avbd_pkg::AGE_W-1:0] a_beat_age_q, a_beat_age_d;
  logic [avbd_pkg::AGE_W-1:0] v_beat_age_q, v_beat_age_d;
  logic [avbd_pkg::AGE_W-1:0] v_fall_age_q, v_fall_age_d;
  logic [avbd_pkg::AGE_W-1:0] a_stim_age_q, a_stim_age_d;
  logic [avbd_pkg::AGE_W-1:0] v_stim_age_q, v_stim_age_d;
  logic                       v_active_q, v_active_d;
  logic                       a_active_q, a_active_d;

  logic                                 line_full;
  logic signed [avbd_pkg::SAMPLE_W-1:0] oldest;
  logic signed [avbd_pkg::PROD_W-1:0]   v_prod, a_prod;
  logic                                 v_bit, a_bit;
  logic                                 v_full, a_full;
  logic [avbd_pkg::V_SUM_W-1:0]         v_count;
  logic [avbd_pkg::A_SUM_W-1:0]         a_count;
  logic                                 v_up, a_up, v_rise, v_fall, a_rise;
  logic [avbd_pkg::AGE_W-1:0]           age_tmp;

  // Oldest sample, zero until the line has filled
  assign line_full = (line_fill_q == avbd_pkg::LINE_FILL_W'(avbd_pkg::LINE_TAPS));
  assign oldest    = line_full ? line_q[avbd_pkg::LINE_TAPS-1] : '0;
  assign line_fill_d = line_full ? line_fill_q : line_fill_q + 1'b1;

  // Polarity and threshold
  assign v_prod = $signed(cfg_i.v_polarity) * $signed(item_i.sample);
  assign a_prod = $signed(cfg_i.a_polarity) * $signed(oldest);
  assign v_bit  = (v_prod > cfg_i.v_threshold);
  assign a_bit  = (a_prod > cfg_i.a_threshold);

  // Ventricular vote window
  assign v_full   = (v_fill_q == avbd_pkg::V_FILL_W'(avbd_pkg::V_WINDOW));
  assign v_count  = v_sum_q + avbd_pkg::V_SUM_W'(v_bit);
  assign v_sum_d  = v_count
                  - avbd_pkg::V_SUM_W'(v_full & v_bits_q[avbd_pkg::V_WINDOW-1]);
  assign v_fill_d = v_full ? v_fill_q : v_fill_q + 1'b1;

  // Atrial vote window
  assign a_full   = (a_fill_q == avbd_pkg::A_FILL_W'(avbd_pkg::A_WINDOW));
  assign a_count  = a_sum_q + avbd_pkg::A_SUM_W'(a_bit);
  assign a_sum_d  = a_count
                  - avbd_pkg::A_SUM_W'(a_full & a_bits_q[avbd_pkg::A_WINDOW-1]);
  assign a_fill_d = a_full ? a_fill_q : a_fill_q + 1'b1;

  // Shift the new vote bits in
  always_comb begin
    v_bits_d[0] = v_bit;
    for (int k = 1; k < avbd_pkg::V_WINDOW; k++) begin
      v_bits_d[k] = v_bits_q[k-1];
    end
    a_bits_d[0] = a_bit;
    for (int k = 1; k < avbd_pkg::A_WINDOW; k++) begin
      a_bits_d[k] = a_bits_q[k-1];
    end
  end

  // Edge detection and ages
  always_comb begin
    age_tmp      = item_i.a_pace_clr ? '0 : a_stim_age_q;
    a_stim_age_d = avbd_pkg::age_inc(age_tmp);
    age_tmp      = item_i.v_pace_clr ? '0 : v_stim_age_q;
    v_stim_age_d = avbd_pkg::age_inc(age_tmp);

    v_up         = (v_count > avbd_pkg::V_SUM_W'(avbd_pkg::V_HALF));
    v_rise       = v_up && !v_active_q;
    v_fall       = !v_up && v_active_q;
    v_active_d   = v_up;
    v_beat_age_d = v_rise ? '0 : avbd_pkg::age_inc(v_beat_age_q);
    v_fall_age_d = v_fall ? '0 : avbd_pkg::age_inc(v_fall_age_q);

    // Atrial rise only counts while the last ventricular fall is newer than its last rise
    a_up         = (a_count > avbd_pkg::A_SUM_W'(avbd_pkg::A_HALF))
                   && (v_beat_age_d > v_fall_age_d);
    a_rise       = a_up && !a_active_q;
    a_active_d   = a_up;
    a_beat_age_d = a_rise ? '0 : avbd_pkg::age_inc(a_beat_age_q);
  end

  // Beat report and stimulus request, ventricular first
  always_comb begin
    priority if (v_rise) begin
      res_o.beat = avbd_pkg::BEAT_VENT;
    end else if (a_rise) begin
      res_o.beat = avbd_pkg::BEAT_ATRIAL;
    end else begin
      res_o.beat = avbd_pkg::BEAT_NONE;
    end

    priority if (v_beat_age_d > a_beat_age_d
                 && a_beat_age_d > avbd_pkg::AGE_W'(cfg_i.v_escape_limit)
                 && v_stim_age_d > avbd_pkg::AGE_W'(cfg_i.v_capture_blank)) begin
      res_o.stim = avbd_pkg::STIM_VENT;
    end else if (a_beat_age_d > avbd_pkg::AGE_W'(cfg_i.a_escape_limit)
                 && a_stim_age_d > avbd_pkg::AGE_W'(cfg_i.a_capture_blank)) begin
      res_o.stim = avbd_pkg::STIM_ATRIAL;
    end else begin
      res_o.stim = avbd_pkg::STIM_NONE;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_fill_q  <= '0;
      v_fill_q     <= '0;
      v_sum_q      <= '0;
      a_fill_q     <= '0;
      a_sum_q      <= '0;
      a_beat_age_q <= '0;
      v_beat_age_q <= '0;
      v_fall_age_q <= '0;
      a_stim_age_q <= '0;
      v_stim_age_q <= '0;
      v_active_q   <= 1'b0;
      a_active_q   <= 1'b0;
    end else if (fire_i) begin
      line_fill_q  <= line_fill_d;
      v_fill_q     <= v_fill_d;
      v_sum_q      <= v_sum_d;
      a_fill_q     <= a_fill_d;
      a_sum_q      <= a_sum_d;
      a_beat_age_q <= a_beat_age_d;
      v_beat_age_q <= v_beat_age_d;
      v_fall_age_q <= v_fall_age_d;
      a_stim_age_q <= a_stim_age_d;
      v_stim_age_q <= v_stim_age_d;
      v_active_q   <= v_active_d;
      a_active_q   <= a_active_d;
    end
  end

  // Sample taps and vote bits, read only once filled
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      line_q[0] <= item_i.sample;
      for (int k = 1; k < avbd_pkg::LINE_TAPS; k++) begin
        line_q[k] <= line_q[k-1];
      end
      v_bits_q <= v_bits_d;
      a_bits_q <= a_bits_d;
    end
  end

endmodule

/* design/avbd_out_buf.sv */
module avbd_out_buf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  avbd_pkg::res_item_t               item_i,
  output logic                              full_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: beat[1:0], stim[3:2], zero pad
  output logic [avbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int CNT_W = $clog2(avbd_pkg::OBUF_DEPTH + 1);
  localparam int PTR_W = $clog2(avbd_pkg::OBUF_DEPTH);

  avbd_pkg::res_item_t mem_q [avbd_pkg::OBUF_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign full_o        = (cnt_q == CNT_W'(avbd_pkg::OBUF_DEPTH));
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = avbd_pkg::OUT_TDATA_W'(mem_q[rd_ptr_q]);

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(avbd_pkg::OBUF_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(avbd_pkg::OBUF_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the result item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/atrial_ventricular_beat_detector_core.sv */
// An input item waits in the input register while the output buffer is full,
// and its result is stored in the output buffer. Throughput: one item per
// cycle while the output buffer has room; the single pass through the detect
// stage sets the figure, and a two-entry output buffer keeps input flowing
// while a result waits. Reset (rst_ni low, asynchronous) clears ages, vote
// sums, fill counts and handshake state and loads the register defaults.
module atrial_ventricular_beat_detector_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: sample[15:0], a_pace_clr[16], v_pace_clr[17], zero pad
  input  logic [avbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: beat[1:0], stim[3:2], zero pad
  output logic [avbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [avbd_pkg::PADDR_W-1:0]      paddr,
  input  logic [avbd_pkg::PDATA_W-1:0]      pwdata,
  output logic [avbd_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  avbd_pkg::cfg_t      cfg;
  avbd_pkg::in_item_t  in_item;
  avbd_pkg::res_item_t res_item;
  logic                in_valid;
  logic                obuf_full;
  logic                fire;

  // Process the held item whenever the output buffer has room
  assign fire = in_valid && !obuf_full;

  avbd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  avbd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take_i        (fire),
    .valid_o       (in_valid),
    .item_o        (in_item)
  );

  avbd_detect u_detect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (in_item),
    .res_o  (res_item)
  );

  avbd_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (fire),
    .item_i        (res_item),
    .full_o        (obuf_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Input stage always drains when the output buffer has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !obuf_full |-> s_axis_tready)
    else $error("input stalled with room in output buffer");

  // A processed item always lands in the output buffer on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed item not offered");

  // Beat and stimulus codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[3:2] != 2'd3))
    else $error("result code out of range");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import avbd_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: sample[15:0], a_pace_clr[16], v_pace_clr[17], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata: beat[1:0], stim[3:2], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  atrial_ventricular_beat_detector_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Free-running clock, 10 ns period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the register file
  cfg_t cfg_sh = '{
    v_threshold:     V_THR_RST,
    a_threshold:     A_THR_RST,
    v_polarity:      V_POL_RST,
    a_polarity:      A_POL_RST,
    a_escape_limit:  A_ESC_RST,
    v_escape_limit:  V_ESC_RST,
    a_capture_blank: A_BLANK_RST,
    v_capture_blank: V_BLANK_RST
  };

  // Detector state as seen by the predictor
  logic signed [SAMPLE_W-1:0] line_buf [DELAY_DEPTH];
  int                         line_wr = 0;
  int                         line_cnt = 0;
  logic [63:0]                vent_bits = '0;
  int                         vent_wr = 0, vent_cnt = 0, vent_sum = 0;
  logic [63:0]                atr_bits = '0;
  int                         atr_wr = 0, atr_cnt = 0, atr_sum = 0;
  logic [AGE_W-1:0]           atr_beat_age = '0, vent_beat_age = '0, vent_fall_age = '0;
  logic [AGE_W-1:0]           atr_stim_age = '0, vent_stim_age = '0;
  logic                       vent_on = 1'b0, atr_on = 1'b0;

  res_item_t beat_stim_q [$];

  bit no_idle = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_cnt = 0;
  int vent_beats = 0, atr_beats = 0, atr_stims = 0, vent_stims = 0;

  function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] age);
    return (age == {AGE_W{1'b1}}) ? age : age + 1'b1;
  endfunction

  // Push one vote bit; return the window sum before the push plus the new bit
  function automatic int window_vote(inout logic [63:0] bits, input int depth, inout int wr,
                                     inout int fill, inout int sum, input bit b);
    int count;
    count = sum + b;
    if (fill >= depth) begin
      sum  = sum - bits[wr];
      fill = depth - 1;
    end
    bits[wr] = b;
    sum      = sum + b;
    fill     = fill + 1;
    wr       = (wr == depth - 1) ? 0 : wr + 1;
    return count;
  endfunction

  // Advance the detector by one accepted item and queue the expected beat/stim
  task automatic predict_beat_stim(input in_item_t it);
    logic signed [SAMPLE_W-1:0] older;
    longint                     vprod, aprod;
    int                         vcount, acount;
    res_item_t                  r;
    if (it.a_pace_clr) atr_stim_age = '0;
    if (it.v_pace_clr) vent_stim_age = '0;

    line_buf[line_wr] = it.sample;
    if (line_cnt < DELAY_DEPTH) line_cnt++;
    line_wr = (line_wr == DELAY_DEPTH - 1) ? 0 : line_wr + 1;
    // atrial path sees zero until the line has filled
    older = (line_cnt >= DELAY_DEPTH) ? line_buf[line_wr] : '0;

    atr_beat_age  = age_step(atr_beat_age);
    vent_beat_age = age_step(vent_beat_age);
    vent_fall_age = age_step(vent_fall_age);
    atr_stim_age  = age_step(atr_stim_age);
    vent_stim_age = age_step(vent_stim_age);

    vprod  = longint'($signed(cfg_sh.v_polarity)) * longint'($signed(it.sample));
    vcount = window_vote(vent_bits, V_WINDOW, vent_wr, vent_cnt, vent_sum,
                         vprod > longint'($signed(cfg_sh.v_threshold)));
    if (vcount > V_HALF) begin
      if (!vent_on) begin
        vent_beat_age = '0;
        vent_on       = 1'b1;
      end
    end else if (vent_on) begin
      vent_fall_age = '0;
      vent_on       = 1'b0;
    end

    aprod  = longint'($signed(cfg_sh.a_polarity)) * longint'($signed(older));
    acount = window_vote(atr_bits, A_WINDOW, atr_wr, atr_cnt, atr_sum,
                         aprod > longint'($signed(cfg_sh.a_threshold)));
    // atrial rise only counts once the ventricle has fallen after its last rise
    if (acount > A_HALF && vent_beat_age > vent_fall_age) begin
      if (!atr_on) begin
        atr_beat_age = '0;
        atr_on       = 1'b1;
      end
    end else if (atr_on) begin
      atr_on = 1'b0;
    end

    if (vent_beat_age == '0 && vent_on) r.beat = BEAT_VENT;
    else if (atr_beat_age == '0 && atr_on) r.beat = BEAT_ATRIAL;
    else r.beat = BEAT_NONE;

    r.stim = STIM_NONE;
    if (atr_beat_age > AGE_W'(cfg_sh.a_escape_limit) &&
        atr_stim_age > AGE_W'(cfg_sh.a_capture_blank))
      r.stim = STIM_ATRIAL;
    // ventricular request wins over atrial
    if (vent_beat_age > atr_beat_age && atr_beat_age > AGE_W'(cfg_sh.v_escape_limit) &&
        vent_stim_age > AGE_W'(cfg_sh.v_capture_blank))
      r.stim = STIM_VENT;

    if (r.beat == BEAT_VENT) vent_beats++;
    if (r.beat == BEAT_ATRIAL) atr_beats++;
    if (r.stim == STIM_ATRIAL) atr_stims++;
    if (r.stim == STIM_VENT) vent_stims++;
    beat_stim_q.push_back(r);
  endtask

  // Send one item after a random gap; predict it at the accepting edge
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic a_rst,
                             input logic v_rst);
    in_item_t it;
    int       gap;
    it.sample     = smp;
    it.a_pace_clr = a_rst;
    it.v_pace_clr = v_rst;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat_stim(it);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (beat_stim_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_V_THR:   cfg_sh.v_threshold     = val[THR_W-1:0];
      REG_A_THR:   cfg_sh.a_threshold     = val[THR_W-1:0];
      REG_V_POL:   cfg_sh.v_polarity      = val[POL_W-1:0];
      REG_A_POL:   cfg_sh.a_polarity      = val[POL_W-1:0];
      REG_A_ESC:   cfg_sh.a_escape_limit  = val[LIM_W-1:0];
      REG_V_ESC:   cfg_sh.v_escape_limit  = val[LIM_W-1:0];
      REG_A_BLANK: cfg_sh.a_capture_blank = val[LIM_W-1:0];
      REG_V_BLANK: cfg_sh.v_capture_blank = val[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load all eight registers once the detector has gone quiet
  task automatic program_detector(input int v_thr, input int a_thr, input int v_pol,
                                  input int a_pol, input int a_esc, input int v_esc,
                                  input int a_blank, input int v_blank);
    drain_results();
    write_reg(REG_V_THR, PDATA_W'(v_thr));
    write_reg(REG_A_THR, PDATA_W'(a_thr));
    write_reg(REG_V_POL, PDATA_W'(v_pol));
    write_reg(REG_A_POL, PDATA_W'(a_pol));
    write_reg(REG_A_ESC, PDATA_W'(a_esc));
    write_reg(REG_V_ESC, PDATA_W'(v_esc));
    write_reg(REG_A_BLANK, PDATA_W'(a_blank));
    write_reg(REG_V_BLANK, PDATA_W'(v_blank));
    settings_cnt++;
  endtask

  // Runs of strong, weak or opposite-sign samples so both vote windows rise and fall;
  // short bursts of raw noise in between
  task automatic send_random_run(input int n_items);
    int left, run_len, mode, s;
    left = n_items;
    while (left > 0) begin
      mode    = $urandom_range(0, 9);
      run_len = (mode >= 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int k = 0; k < run_len && left > 0; k++) begin
        if (mode <= 2) s = $urandom_range(1000, 32767);
        else if (mode <= 5) s = -int'($urandom_range(1000, 32768));
        else if (mode <= 7) s = int'($urandom_range(0, 8000)) - 4000;
        else s = int'($urandom_range(0, 65535));
        push_sample(SAMPLE_W'(s), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        left--;
      end
    end
  endtask

  // Field extremes and both reset strobes with register defaults, while the line fills up
  task automatic test_directed();
    int smp [24] = '{32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                     0, -1, 1, 32767, 32767, 161, -161, -162, 72, 73, -32768, 0,
                     32767, -32768, 12345, -12345};
    for (int i = 0; i < 24; i++)
      push_sample(SAMPLE_W'(smp[i]), i[0], i[1]);
  endtask

  task automatic test_default_settings();
    program_detector(161, 72, -1, 1, 1000, 900, 30, 11);
    send_random_run(250);
  endtask

  // Tight escape limits so stimulus requests come often
  task automatic test_short_escape();
    program_detector(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                     1, -1, $urandom_range(0, 40), $urandom_range(0, 40),
                     $urandom_range(0, 15), $urandom_range(0, 15));
    send_random_run(350);
  endtask

  // Threshold and limit extremes, polarity 0 and the -2 pattern
  task automatic test_extremes();
    program_detector(65535, -65536, -2, 0, 0, 0, 0, 0);
    // -2 * -32768 just clears the top threshold
    for (int i = 0; i < 12; i++) push_sample(16'sh8000, 1'b0, 1'b0);
    for (int i = 0; i < 12; i++) push_sample(16'sh7fff, 1'b1, 1'b1);
    send_random_run(150);
    program_detector(-65536, 65535, 0, -2, 65535, 65535, 65535, 65535);
    send_random_run(150);
  endtask

  // Random settings, one round with no idling on either side
  task automatic test_random_settings();
    for (int round = 0; round < 3; round++) begin
      program_detector(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 131071)) - 65536
                                                   : int'($urandom_range(0, 6000)) - 3000,
                       ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 131071)) - 65536
                                                   : int'($urandom_range(0, 6000)) - 3000,
                       $urandom_range(0, 3), $urandom_range(0, 3),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 200),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 200),
                       $urandom_range(0, 50), $urandom_range(0, 50));
      no_idle = (round == 1);
      send_random_run(200);
    end
    no_idle = 1'b0;
  endtask

  // Accept results with random stalls and check them against the oldest expectation
  initial begin : result_check
    res_item_t got;
    res_item_t want;
    int        stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got = res_item_t'(m_axis_tdata[RES_ITEM_W-1:0]);
      if (beat_stim_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual beat %0d stim %0d",
                 $time, got.beat, got.stim);
        errors++;
      end else begin
        want = beat_stim_q.pop_front();
        if (got.beat !== want.beat) begin
          $display("%0t: beat mismatch, expected %0d, actual %0d", $time, want.beat, got.beat);
          errors++;
        end
        if (got.stim !== want.stim) begin
          $display("%0t: stim mismatch, expected %0d, actual %0d", $time, want.stim, got.stim);
          errors++;
        end
      end
      results_checked++;
    end
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (int i = 0; i < DELAY_DEPTH; i++) line_buf[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_default_settings();
    test_short_escape();
    test_extremes();
    test_random_settings();
    drain_results();

    $display("Checked %0d results from %0d items over %0d register settings",
             results_checked, items_sent, settings_cnt);
    $display("Beats: %0d ventricular, %0d atrial; stimulus: %0d atrial, %0d ventricular",
             vent_beats, atr_beats, atr_stims, vent_stims);
    if (errors == 0 && beat_stim_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
